// File: rtl/core/sbps_pkg.sv
// ----------------------------------------------------------------------------
// Smart battery poll sequencer package
// Shared types, protocol constants and the poll command table.
// ----------------------------------------------------------------------------
package sbps_pkg;

	localparam logic [6:0] BUS_ADDRESS = 7'd11;
	localparam logic [7:0] WADDR       = {BUS_ADDRESS, 1'b0};
	localparam logic [7:0] RADDR       = {BUS_ADDRESS, 1'b1};

	localparam logic [7:0]  CRC_POLY        = 8'h07;
	localparam logic [7:0]  MODE_CMD        = 8'h03;
	localparam logic [15:0] DISCHARGING_BIT = 16'h0040;
	localparam logic [15:0] TEMP_RESET      = 16'd2730;

	localparam logic [7:0] POLL_PERIOD_RESET = 8'd20;
	localparam logic [7:0] ERROR_LIMIT_RESET = 8'd150;
	localparam logic [15:0] MODE_WORD_RESET  = 16'h6000;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_POLL_PERIOD = 2'd0;
	localparam logic [1:0] REG_ERROR_LIMIT = 2'd1;
	localparam logic [1:0] REG_MODE_WORD   = 2'd2;

	// Poll steps and the field codes they report.
	localparam logic [3:0] STEP_MODE    = 4'd0;
	localparam logic [3:0] STEP_STATUS  = 4'd1;
	localparam logic [3:0] STEP_PCT     = 4'd2;
	localparam logic [3:0] STEP_CAP     = 4'd3;
	localparam logic [3:0] STEP_TEMP    = 4'd4;
	localparam logic [3:0] STEP_VOLT    = 4'd5;
	localparam logic [3:0] STEP_CURR    = 4'd6;
	localparam logic [3:0] STEP_EMPTY   = 4'd7;
	localparam logic [3:0] STEP_FULL    = 4'd8;
	localparam logic [3:0] STEP_DESIGN  = 4'd9;
	localparam logic [3:0] FIELD_NONE   = 4'd0;

	localparam int DIV_STEPS = 23;
	localparam logic [22:0] HEALTH_NO_DESIGN = 23'd100;

	typedef struct packed {
		logic       battery_absent;
		logic       write_ack;
		logic       read_ack;
		logic [7:0] resp_low;
		logic [7:0] resp_high;
		logic [7:0] resp_pec;
	} in_item_t;

	typedef struct packed {
		logic        txn_issued;
		logic        txn_is_write;
		logic [7:0]  txn_command;
		logic [15:0] txn_write_word;
		logic [7:0]  txn_pec;
		logic        connected;
		logic        comm_failure;
		logic [3:0]  updated_field;
		logic [15:0] updated_value;
		logic        charging;
		logic [22:0] health_percent;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic din;
	} crc_ctrl_t;

	typedef struct packed {
		logic        start;
		logic [22:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_REQ,
		ST_CHK,
		ST_APPLY,
		ST_DSTART,
		ST_DIV,
		ST_OUT
	} sbps_state_t;

	function automatic logic [7:0] read_command(input logic [3:0] step);
		logic [7:0] c;
		case (step)
			STEP_STATUS: c = 8'h16;
			STEP_PCT:    c = 8'h0d;
			STEP_CAP:    c = 8'h0f;
			STEP_TEMP:   c = 8'h08;
			STEP_VOLT:   c = 8'h09;
			STEP_CURR:   c = 8'h0a;
			STEP_EMPTY:  c = 8'h12;
			STEP_FULL:   c = 8'h10;
			STEP_DESIGN: c = 8'h18;
			default:     c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/sbps_crc.sv
// ----------------------------------------------------------------------------
// Bit-serial CRC-8 unit
// Takes one message bit per cycle while enabled, most significant bit of each byte first.
// ----------------------------------------------------------------------------
module sbps_crc import sbps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  crc_ctrl_t ctrl,
	output logic [7:0] crc
);

	logic [7:0] crc_q;
	logic [7:0] crc_next;

	// Feedback is the top bit against the incoming bit.
	assign crc_next = {crc_q[6:0], 1'b0} ^ ((crc_q[7] ^ ctrl.din) ? CRC_POLY : 8'h00);
	assign crc = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
		end else if (ctrl.clr) begin
			crc_q <= 8'h00;
		end else if (ctrl.en) begin
			crc_q <= crc_next;
		end
	end

endmodule

// File: rtl/core/sbps_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle; a zero divisor yields the fixed value.
// ----------------------------------------------------------------------------
module sbps_div import sbps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        busy,
	output logic [22:0] quotient
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [22:0] quo_q;
	logic [15:0] dvs_q;
	logic [17:0] trial;
	logic        neg;

	assign trial = {1'b0, rem_q, quo_q[22]} - {2'b00, dvs_q};
	assign neg = trial[17];
	assign busy = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (req.start) begin
			busy_q <= (req.divisor != 16'd0);
			cnt_q  <= 5'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 16'd0;
			dvs_q <= req.divisor;
			quo_q <= (req.divisor == 16'd0) ? HEALTH_NO_DESIGN : req.dividend;
		end else if (busy_q) begin
			rem_q <= neg ? {rem_q[14:0], quo_q[22]} : trial[15:0];
			quo_q <= {quo_q[21:0], ~neg};
		end
	end

endmodule

// File: rtl/core/smart_battery_poll_sequencer.sv
// ----------------------------------------------------------------------------
// Smart battery poll sequencer
// Tick-driven SMBus smart battery poller with CRC-8 packet error checking.
// ----------------------------------------------------------------------------
// Each input transaction is one task tick and yields exactly one result
// transaction. A tick is worked on alone: the block latches it, runs the
// request PEC through a bit-serial CRC-8 unit (16 bits for a read, 32 bits
// for the mode write), reuses the same unit for the 24-bit check of the
// read answer, applies the poll outcome and then recomputes state of health
// with a restoring divider that yields one quotient bit per cycle. The
// 24-bit answer check always runs, even when nothing was issued. How long a
// tick takes is set by the serial CRC passes and the 23 divider iterations;
// with a zero design capacity the divider finishes at once. The result
// sits in an output register, so the next tick may be accepted while it
// waits. Configuration writes take effect at once and should be made
// while idle.
// ----------------------------------------------------------------------------
module smart_battery_poll_sequencer import sbps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [7:0]  poll_period_q;
	logic [7:0]  error_limit_q;
	logic [15:0] mode_word_q;

	// Poller state.
	logic [7:0]  tick_q;
	logic        link_q;
	logic [3:0]  step_q;
	logic [7:0]  fail_q;
	logic        sticky_q;
	logic [15:0] status_q, pct_q, cap_q, temp_q, volt_q, curr_q, empty_q, full_q, design_q;

	// Per-tick working registers.
	sbps_state_t state_q, state_d;
	in_item_t    in_q;
	logic        txn_q;
	logic        issued_q, is_write_q;
	logic [7:0]  cmd_q, pec_q;
	logic [15:0] wword_q;
	logic [3:0]  ufield_q;
	logic [15:0] uvalue_q;
	logic [31:0] sh_q;
	logic [5:0]  cnt_q;

	logic        out_valid_q;
	out_item_t   out_q;

	// Shared units.
	crc_ctrl_t   crc_ctrl;
	logic [7:0]  crc;
	div_req_t    div_req;
	logic        div_busy;
	logic [22:0] div_quo;

	sbps_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc)
	);

	sbps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Decisions taken in the preparation cycle.
	logic        act;
	logic        now_up;
	logic        link_new;
	logic        clearing;
	logic [3:0]  step_eff;
	logic        txn_new;
	logic        is_read_step;
	logic [7:0]  fail_inc;

	always_comb begin
		act          = (tick_q >= poll_period_q);
		now_up       = ~in_q.battery_absent;
		link_new     = act ? now_up : link_q;
		clearing     = act && link_q && !now_up;
		step_eff     = clearing ? STEP_MODE : step_q;
		txn_new      = act && link_new;
		is_read_step = step_eff inside {[STEP_STATUS:STEP_DESIGN]};
		fail_inc     = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_PREP;
			ST_PREP:   state_d = ST_REQ;
			ST_REQ:    if (cnt_q == 6'd0) state_d = ST_CHK;
			ST_CHK:    if (cnt_q == 6'd0) state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    if (!div_busy) state_d = ST_OUT;
			ST_OUT:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		crc_ctrl.clr = (state_q == ST_PREP) || ((state_q == ST_REQ) && (cnt_q == 6'd0));
		crc_ctrl.en  = ((state_q == ST_REQ) || (state_q == ST_CHK)) && (cnt_q != 6'd0);
		crc_ctrl.din = sh_q[31];
		div_req.start    = (state_q == ST_DSTART);
		div_req.dividend = {1'b0, full_q, 6'd0} + {2'b00, full_q, 5'd0} + {5'd0, full_q, 2'd0};
		div_req.divisor  = design_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q <= POLL_PERIOD_RESET;
			error_limit_q <= ERROR_LIMIT_RESET;
			mode_word_q   <= MODE_WORD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL_PERIOD: poll_period_q <= cfg_data[7:0];
				REG_ERROR_LIMIT: error_limit_q <= cfg_data[7:0];
				REG_MODE_WORD:   mode_word_q   <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Poller state, updated in the preparation and apply cycles. The tick
	// counter has already moved on by the apply cycle, so the decision to
	// act is taken from the flag latched during preparation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= 8'd0;
			link_q   <= 1'b0;
			step_q   <= STEP_MODE;
			fail_q   <= 8'd0;
			sticky_q <= 1'b0;
			status_q <= DISCHARGING_BIT;
			pct_q    <= 16'd0;
			cap_q    <= 16'd0;
			temp_q   <= TEMP_RESET;
			volt_q   <= 16'd0;
			curr_q   <= 16'd0;
			empty_q  <= 16'd0;
			full_q   <= 16'd0;
			design_q <= 16'd0;
		end else if (state_q == ST_PREP) begin
			tick_q <= act ? 8'd0 : tick_q + 8'd1;
			link_q <= link_new;
			if (clearing) begin
				// Losing the battery drops the live readings but keeps the full and
				// design capacities, the time to empty and the current reading.
				step_q   <= STEP_MODE;
				pct_q    <= 16'd0;
				cap_q    <= 16'd0;
				temp_q   <= TEMP_RESET;
				volt_q   <= 16'd0;
				status_q <= DISCHARGING_BIT;
			end
		end else if ((state_q == ST_APPLY) && txn_q) begin
			if (step_q == STEP_MODE) begin
				if (in_q.write_ack) begin
					fail_q <= 8'd0;
					step_q <= STEP_STATUS;
				end else begin
					fail_q <= fail_inc;
					if (fail_inc >= error_limit_q) sticky_q <= 1'b1;
				end
			end else if (step_q inside {[STEP_STATUS:STEP_DESIGN]}) begin
				if (!in_q.write_ack || !in_q.read_ack) begin
					fail_q <= fail_inc;
					if (fail_inc >= error_limit_q) sticky_q <= 1'b1;
				end else begin
					// Both phases completed, so the bus is healthy even when
					// the answer fails its PEC check.
					fail_q <= 8'd0;
					if (crc == in_q.resp_pec) begin
						case (step_q)
							STEP_STATUS: status_q <= {in_q.resp_high, in_q.resp_low};
							STEP_PCT:    pct_q    <= {in_q.resp_high, in_q.resp_low};
							STEP_CAP:    cap_q    <= {in_q.resp_high, in_q.resp_low};
							STEP_TEMP:   temp_q   <= {in_q.resp_high, in_q.resp_low};
							STEP_VOLT:   volt_q   <= {in_q.resp_high, in_q.resp_low};
							STEP_CURR:   curr_q   <= {in_q.resp_high, in_q.resp_low};
							STEP_EMPTY:  empty_q  <= {in_q.resp_high, in_q.resp_low};
							STEP_FULL:   full_q   <= {in_q.resp_high, in_q.resp_low};
							default:     design_q <= {in_q.resp_high, in_q.resp_low};
						endcase
						step_q <= (step_q == STEP_DESIGN) ? STEP_MODE : step_q + 4'd1;
					end
				end
			end else begin
				// A step code outside the poll restarts the round.
				step_q <= STEP_MODE;
			end
		end
	end

	// Per-tick datapath: latched item, CRC message shifter and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) in_q <= in_data;
			end
			ST_PREP: begin
				txn_q      <= txn_new;
				issued_q   <= txn_new && ((step_eff == STEP_MODE) || is_read_step);
				is_write_q <= txn_new && (step_eff == STEP_MODE);
				ufield_q   <= FIELD_NONE;
				uvalue_q   <= 16'd0;
				if (txn_new && (step_eff == STEP_MODE)) begin
					cmd_q   <= MODE_CMD;
					wword_q <= mode_word_q;
					sh_q    <= {WADDR, MODE_CMD, mode_word_q[7:0], mode_word_q[15:8]};
					cnt_q   <= 6'd32;
				end else if (txn_new && is_read_step) begin
					cmd_q   <= read_command(step_eff);
					wword_q <= 16'd0;
					sh_q    <= {WADDR, read_command(step_eff), 16'd0};
					cnt_q   <= 6'd16;
				end else begin
					cmd_q   <= 8'd0;
					wword_q <= 16'd0;
					sh_q    <= 32'd0;
					cnt_q   <= 6'd0;
				end
			end
			ST_REQ: begin
				if (cnt_q != 6'd0) begin
					sh_q  <= {sh_q[30:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
				end else begin
					// The CRC is zero when nothing was issued.
					pec_q <= crc;
					sh_q  <= {RADDR, in_q.resp_low, in_q.resp_high, 8'd0};
					cnt_q <= 6'd24;
				end
			end
			ST_CHK: begin
				if (cnt_q != 6'd0) begin
					sh_q  <= {sh_q[30:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
				end
			end
			ST_APPLY: begin
				if (txn_q && (step_q inside {[STEP_STATUS:STEP_DESIGN]}) && in_q.write_ack
					&& in_q.read_ack && (crc == in_q.resp_pec)) begin
					ufield_q <= step_q;
					uvalue_q <= {in_q.resp_high, in_q.resp_low};
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.txn_issued     <= issued_q;
					out_q.txn_is_write   <= is_write_q;
					out_q.txn_command    <= cmd_q;
					out_q.txn_write_word <= wword_q;
					out_q.txn_pec        <= pec_q;
					out_q.connected      <= link_q;
					out_q.comm_failure   <= sticky_q;
					out_q.updated_field  <= ufield_q;
					out_q.updated_value  <= uvalue_q;
					out_q.charging       <= ~|(status_q & DISCHARGING_BIT);
					out_q.health_percent <= div_quo;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: tb/tb_smart_battery_poll_sequencer.sv
// ----------------------------------------------------------------------------
// Smart battery poll sequencer testbench
// Drives task ticks through the valid/ready input channel, predicts every
// result transaction with a behavioural model of the poller, and checks
// each field. A short directed walk is followed by randomised poll rounds.
// ----------------------------------------------------------------------------
module tb_smart_battery_poll_sequencer;
	import sbps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The fourth register index decodes to nothing and must be ignored.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Commands issued by each poll step, step 0 being the mode write.
	localparam logic [9:0][7:0] POLL_READ_CMD = {
		8'h18, 8'h10, 8'h12, 8'h0a, 8'h09, 8'h08, 8'h0f, 8'h0d, 8'h16, 8'h00
	};

	// The watchdog limit covers the whole run with a wide margin.
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int          RANDOM_PHASES   = 12;
	localparam int          TICKS_PER_PHASE = 52;
	localparam int          MAX_REPORTS     = 100;

	// How the PEC byte of a read answer is formed for a stimulus tick.
	typedef enum logic [1:0] {
		PEC_RAW,
		PEC_GOOD,
		PEC_BAD
	} pec_mode_e;

	typedef enum logic {
		ROW_TICK,
		ROW_REGS
	} row_kind_e;

	// One line of the directed walk: either a tick or a set of register values.
	typedef struct packed {
		row_kind_e   kind;
		in_item_t    tick;
		pec_mode_e   pec;
		logic        typed;
		out_item_t   want;
		logic [7:0]  period;
		logic [7:0]  limit;
		logic [15:0] mode;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Register copies held by the predictor.
	logic [7:0]  cfg_period = POLL_PERIOD_RESET;
	logic [7:0]  cfg_limit = ERROR_LIMIT_RESET;
	logic [15:0] cfg_mode = MODE_WORD_RESET;

	// Poller state as the predictor sees it.
	logic [7:0]  ticks_since_poll = '0;
	logic        battery_linked = 1'b0;
	logic [3:0]  poll_pos = STEP_MODE;
	logic [7:0]  bus_fail_run = '0;
	logic        fail_flag = 1'b0;
	logic [15:0] rd_status = DISCHARGING_BIT;
	logic [15:0] rd_pct = '0;
	logic [15:0] rd_cap = '0;
	logic [15:0] rd_temp = TEMP_RESET;
	logic [15:0] rd_volt = '0;
	logic [15:0] rd_curr = '0;
	logic [15:0] rd_tte = '0;
	logic [15:0] rd_full = '0;
	logic [15:0] rd_design = '0;

	// Results predicted for accepted ticks, oldest first.
	out_item_t tick_results_due [$];

	int mismatches = 0;
	int ticks_sent = 0;
	int polls_acted = 0;
	int readings_stored = 0;
	int bus_failures = 0;
	int gap_max = 3;

	smart_battery_poll_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// SMBus PEC: CRC-8 with polynomial x^8+x^2+x+1, worked a byte at a time.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// The PEC a well-behaved battery appends to a word read.
	function automatic logic [7:0] answer_pec(input logic [7:0] lo, input logic [7:0] hi);
		return crc8_byte(crc8_byte(crc8_byte(8'h00, RADDR), lo), hi);
	endfunction

	function automatic in_item_t with_pec(input in_item_t t, input pec_mode_e pm);
		in_item_t r;
		r = t;
		case (pm)
			PEC_GOOD: r.resp_pec = answer_pec(t.resp_low, t.resp_high);
			PEC_BAD:  r.resp_pec = answer_pec(t.resp_low, t.resp_high) ^ 8'h5a;
			default:  r.resp_pec = t.resp_pec;
		endcase
		return r;
	endfunction

	// Data bytes lean towards the extremes now and then.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7, 0))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic step_row_t tick_row(input logic absent, input logic wack,
			input logic rack, input logic [7:0] lo, input logic [7:0] hi,
			input pec_mode_e pm);
		step_row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.tick.battery_absent = absent;
		r.tick.write_ack = wack;
		r.tick.read_ack = rack;
		r.tick.resp_low = lo;
		r.tick.resp_high = hi;
		r.pec = pm;
		return r;
	endfunction

	// A tick that changes nothing visible before any reading has been stored:
	// no transaction, no store, still discharging and a health of 100.
	function automatic step_row_t quiet_row(input logic absent);
		step_row_t r;
		r = tick_row(absent, 1'b0, 1'b0, 8'h00, 8'h00, PEC_RAW);
		r.typed = 1'b1;
		r.want = '0;
		r.want.health_percent = HEALTH_NO_DESIGN;
		return r;
	endfunction

	function automatic step_row_t regs_row(input logic [7:0] period, input logic [7:0] limit,
			input logic [15:0] mode);
		step_row_t r;
		r = '0;
		r.kind = ROW_REGS;
		r.period = period;
		r.limit = limit;
		r.mode = mode;
		return r;
	endfunction

	task automatic count_bus_failure();
		bus_failures++;
		if (bus_fail_run != 8'hff)
			bus_fail_run++;
		if (bus_fail_run >= cfg_limit)
			fail_flag = 1'b1;
	endtask

	// Works out the result of one tick and advances the predicted poller state.
	task automatic predict_poll_tick(input in_item_t t, output out_item_t r);
		logic        now_up;
		logic [15:0] word;
		logic [31:0] ratio;
		r = '0;
		if (ticks_since_poll >= cfg_period) begin
			polls_acted++;
			ticks_since_poll = '0;
			now_up = ~t.battery_absent;
			if (battery_linked != now_up) begin
				battery_linked = now_up;
				// Losing the battery restarts the round and forgets the live readings;
				// current, time to empty and both capacities survive.
				if (!now_up) begin
					poll_pos = STEP_MODE;
					rd_pct = '0;
					rd_cap = '0;
					rd_temp = TEMP_RESET;
					rd_volt = '0;
					rd_status = DISCHARGING_BIT;
				end
			end
			if (battery_linked) begin
				if (poll_pos == STEP_MODE) begin
					r.txn_issued = 1'b1;
					r.txn_is_write = 1'b1;
					r.txn_command = MODE_CMD;
					r.txn_write_word = cfg_mode;
					r.txn_pec = crc8_byte(crc8_byte(crc8_byte(crc8_byte(8'h00, WADDR),
						MODE_CMD), cfg_mode[7:0]), cfg_mode[15:8]);
					if (t.write_ack) begin
						bus_fail_run = '0;
						poll_pos = STEP_STATUS;
					end else begin
						count_bus_failure();
					end
				end else if (poll_pos <= STEP_DESIGN) begin
					r.txn_issued = 1'b1;
					r.txn_command = POLL_READ_CMD[poll_pos];
					r.txn_pec = crc8_byte(crc8_byte(8'h00, WADDR), POLL_READ_CMD[poll_pos]);
					if (!t.write_ack || !t.read_ack) begin
						count_bus_failure();
					end else begin
						// The bus worked, so the failure run ends even if the PEC is bad.
						bus_fail_run = '0;
						if (answer_pec(t.resp_low, t.resp_high) == t.resp_pec) begin
							word = {t.resp_high, t.resp_low};
							case (poll_pos)
								STEP_STATUS: rd_status = word;
								STEP_PCT:    rd_pct = word;
								STEP_CAP:    rd_cap = word;
								STEP_TEMP:   rd_temp = word;
								STEP_VOLT:   rd_volt = word;
								STEP_CURR:   rd_curr = word;
								STEP_EMPTY:  rd_tte = word;
								STEP_FULL:   rd_full = word;
								default:     rd_design = word;
							endcase
							readings_stored++;
							r.updated_field = poll_pos;
							r.updated_value = word;
							poll_pos = (poll_pos == STEP_DESIGN) ? STEP_MODE : poll_pos + 4'd1;
						end
					end
				end else begin
					poll_pos = STEP_MODE;
				end
			end
		end else begin
			ticks_since_poll++;
		end

		if (rd_design != 16'd0)
			ratio = (32'd100 * {16'd0, rd_full}) / {16'd0, rd_design};
		else
			ratio = {9'd0, HEALTH_NO_DESIGN};
		r.connected = battery_linked;
		r.comm_failure = fail_flag;
		r.charging = (rd_status & DISCHARGING_BIT) == 16'd0;
		r.health_percent = ratio[22:0];
	endtask

	// Offers one tick after a random gap and records what it should produce.
	// Valid is only lowered when there is a gap, so back-to-back ticks keep it
	// high across the edge without a second assignment in the same step.
	task automatic offer_tick(input in_item_t t, input logic typed, input out_item_t want);
		int        gap;
		out_item_t guess;
		gap = $urandom_range(gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_ready !== 1'b1);
		ticks_sent++;
		predict_poll_tick(t, guess);
		tick_results_due.push_back(typed ? want : guess);
	endtask

	// Stops offering and waits until every predicted result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		while (tick_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three registers plus the spare index while the block is idle.
	// The upper byte of the 8-bit registers carries junk that must be dropped.
	task automatic program_regs(input logic [7:0] period, input logic [7:0] limit,
			input logic [15:0] mode);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_POLL_PERIOD;
		cfg_data <= {8'($urandom), period};
		@(posedge clk);
		cfg_index <= REG_ERROR_LIMIT;
		cfg_data <= {8'($urandom), limit};
		@(posedge clk);
		cfg_index <= REG_MODE_WORD;
		cfg_data <= mode;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_period = period;
		cfg_limit = limit;
		cfg_mode = mode;
	endtask

	task automatic check_field(input string field, input logic [22:0] want,
			input logic [22:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endtask

	// Stimulus: reset, the directed walk, then the randomised poll rounds.
	initial begin : stimulus
		step_row_t   directed [$];
		in_item_t    item;
		int          roll;
		int          fail_pct;
		logic [7:0]  period;
		logic [7:0]  limit;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			// Reset settings: the divider holds the first ticks back.
			quiet_row(1'b0),
			regs_row(8'd255, 8'd255, 16'hffff),
			quiet_row(1'b0),
			quiet_row(1'b0),
			// The count left from the slow divider is above the new period, so
			// the very next tick acts. No battery yet, so still nothing is issued.
			regs_row(8'd0, 8'd255, 16'hffff),
			quiet_row(1'b1),
			// Battery arrives; the mode write is refused, then accepted.
			tick_row(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, PEC_RAW),
			tick_row(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, PEC_RAW),
			tick_row(1'b0, 1'b1, 1'b1, 8'h00, 8'h00, PEC_GOOD),
			// Read phase fails, write phase fails with a plausible answer, and a
			// good bus transaction whose PEC does not match.
			tick_row(1'b0, 1'b1, 1'b0, 8'h12, 8'h34, PEC_GOOD),
			tick_row(1'b0, 1'b0, 1'b1, 8'h12, 8'h34, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'h12, 8'h34, PEC_BAD),
			// The rest of the round with extreme words; a full capacity of 0xffff
			// over a design capacity of 1 gives the largest health figure.
			tick_row(1'b0, 1'b1, 1'b1, 8'hff, 8'hff, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'h00, 8'h80, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'haa, 8'h55, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'h55, 8'haa, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'hff, 8'hff, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'h01, 8'h00, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'hff, 8'hff, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b1, 8'h01, 8'h00, PEC_GOOD),
			// Disconnect keeps the capacities, then a new round writes mode zero.
			regs_row(8'd0, 8'd255, 16'h0000),
			tick_row(1'b1, 1'b1, 1'b1, 8'h00, 8'h00, PEC_GOOD),
			tick_row(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, PEC_RAW),
			tick_row(1'b0, 1'b1, 1'b1, 8'h40, 8'h00, PEC_GOOD),
			tick_row(1'b1, 1'b1, 1'b1, 8'h77, 8'h66, PEC_GOOD)
		};

		foreach (directed[k]) begin
			if (directed[k].kind == ROW_REGS)
				program_regs(directed[k].period, directed[k].limit, directed[k].mode);
			else
				offer_tick(with_pec(directed[k].tick, directed[k].pec), directed[k].typed,
					directed[k].want);
		end

		// Random rounds. Most ticks are well-formed polls with random data; a few
		// pull the battery or corrupt the bus. The last two phases use a tiny
		// error limit and a high failure rate so the sticky flag gets set.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				period = 8'd0;
			else if (phase == 5)
				period = 8'($urandom_range(12, 4));
			else
				period = 8'($urandom_range(3, 0));
			if (phase == RANDOM_PHASES - 1)
				limit = 8'($urandom_range(1, 0));
			else if (phase == RANDOM_PHASES - 2)
				limit = 8'($urandom_range(6, 2));
			else
				limit = 8'($urandom_range(255, 100));
			program_regs(period, limit, 16'($urandom));
			gap_max = phase[0] ? 0 : 3;
			fail_pct = (phase >= RANDOM_PHASES - 2) ? 45 : 8;
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				item.battery_absent = $urandom_range(99, 0) < 3;
				item.write_ack = $urandom_range(99, 0) >= fail_pct;
				item.read_ack = $urandom_range(99, 0) >= fail_pct;
				item.resp_low = pick_byte();
				item.resp_high = pick_byte();
				item.resp_pec = 8'($urandom);
				roll = $urandom_range(99, 0);
				item = with_pec(item, (roll < 88) ? PEC_GOOD : (roll < 95) ? PEC_BAD : PEC_RAW);
				offer_tick(item, 1'b0, '0);
			end
		end

		// Drain, then leave room for any stray result to show up as unexpected.
		settle();
		repeat (200) @(posedge clk);
		$display("Run covered %0d ticks (%0d directed), %0d of them acting on the bus side,",
			ticks_sent, directed.size() - 3, polls_acted);
		$display("with %0d readings stored, %0d bus failures and the failure flag ending at %0b.",
			readings_stored, bus_failures, fail_flag);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side. Stalls are drawn per transaction, with stretches of none,
	// and once, while ticks are still being offered, the receiver holds off
	// long enough for the output register and the working slot to fill so
	// that the input is throttled.
	initial begin : result_sink
		int        stall;
		int        taken;
		bit        long_hold_done;
		out_item_t got;
		out_item_t want;
		taken = 0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = ((taken / 40) % 2 == 1) ? $urandom_range(3, 0) : 0;
			if (!long_hold_done && taken >= 150 && in_valid === 1'b1) begin
				stall = 300;
				long_hold_done = 1'b1;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = out_data;
			taken++;
			if (tick_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing predicted, expected none, got 0x%0h",
					$time, got);
			end else begin
				want = tick_results_due.pop_front();
				check_field("txn_issued", want.txn_issued, got.txn_issued);
				check_field("txn_is_write", want.txn_is_write, got.txn_is_write);
				check_field("txn_command", want.txn_command, got.txn_command);
				check_field("txn_write_word", want.txn_write_word, got.txn_write_word);
				check_field("txn_pec", want.txn_pec, got.txn_pec);
				check_field("connected", want.connected, got.connected);
				check_field("comm_failure", want.comm_failure, got.comm_failure);
				check_field("updated_field", want.updated_field, got.updated_field);
				check_field("updated_value", want.updated_value, got.updated_value);
				check_field("charging", want.charging, got.charging);
				check_field("health_percent", want.health_percent, got.health_percent);
			end
		end
	end

	// Watchdog: a lost or stuck transaction ends the run here.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run exceeded %0d cycles with %0d results outstanding.", CYCLE_LIMIT,
			tick_results_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
